[hdl/bdcc_pkg.sv]
package bdcc_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CLICK_W = 2;

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CLICK_W-1:0]   click_t;

  localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t REG_DC_WIN   = 2'd1;
  localparam cfg_idx_t REG_LONG     = 2'd2;

  localparam cfg_t DEBOUNCE_RST = 16'd50;
  localparam cfg_t DC_WIN_RST   = 16'd300;
  localparam cfg_t LONG_RST     = 16'd1000;

  localparam click_t CLICK_MAX = 2'd3;
  localparam click_t CLICK_DBL = 2'd2;

  // Elapsed time, wrapping.
  function automatic time_t tdiff(input time_t a, input time_t b);
    tdiff = a - b;
  endfunction

endpackage

[hdl/button_debounce_click_classifier.sv]
// Path: a sample accepted into the input register has its result in the output
// register next (input register, then result register).
// Throughput: one sample per cycle; the input register loads whenever it is empty
// or moving on, and it moves on whenever the result register is empty or taken.
// Reset (rst, synchronous, active high): pipeline empty, tracking state cleared,
// debounce_time = 50, double_click_window = 300, long_press_time = 1000.
module button_debounce_click_classifier (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  bdcc_pkg::cfg_idx_t     cfg_index,
  input  bdcc_pkg::cfg_t         cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   raw_pressed,
  input  logic [31:0]            now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   feedback_bright,
  output logic                   long_press,
  output logic                   short_press,
  output logic                   double_click
);
  import bdcc_pkg::*;

  // configuration registers
  cfg_t debounce_time;
  cfg_t double_click_window;
  cfg_t long_press_time;

  // input register
  logic  s1_valid;
  logic  s1_raw;
  time_t s1_now;

  // tracking state
  logic   raw_level;
  logic   stable_level;
  time_t  change_time;
  time_t  press_start;
  time_t  release_time;
  click_t clicks;
  logic   short_pending;
  time_t  short_deadline;
  logic   long_fired;

  // next values
  logic   raw_level_next;
  logic   stable_level_next;
  time_t  change_time_next;
  time_t  press_start_next;
  time_t  release_time_next;
  click_t clicks_next;
  logic   short_pending_next;
  time_t  short_deadline_next;
  logic   long_fired_next;
  logic   lp_next;
  logic   sp_next;
  logic   dc_next;

  logic   advance;
  logic   raw_chg;
  logic   debounced;
  click_t click_inc;

  // The pipeline moves when the result register is empty or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time       <= DEBOUNCE_RST;
      double_click_window <= DC_WIN_RST;
      long_press_time     <= LONG_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_time       <= cfg_data;
        REG_DC_WIN:   double_click_window <= cfg_data;
        REG_LONG:     long_press_time     <= cfg_data;
        default: ; // indexes past the list are ignored
      endcase
    end
  end

  // Stage 1: capture the sample transaction; loads when empty or moving on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_raw <= raw_pressed;
      s1_now <= time_t'(now_ms);
    end
  end

  // Classification: one pass per sample, steps in the same order as the
  // behavior is defined (raw edge, debounce, long press, short deadline).
  always_comb begin
    raw_level_next      = raw_level;
    stable_level_next   = stable_level;
    change_time_next    = change_time;
    press_start_next    = press_start;
    release_time_next   = release_time;
    clicks_next         = clicks;
    short_pending_next  = short_pending;
    short_deadline_next = short_deadline;
    long_fired_next     = long_fired;
    lp_next             = 1'b0;
    sp_next             = 1'b0;
    dc_next             = 1'b0;
    click_inc           = (clicks < CLICK_MAX) ? clicks + click_t'(1) : clicks;

    // Raw edge: press timing restarts before any debouncing.
    raw_chg = s1_raw != raw_level;
    if (raw_chg) begin
      change_time_next = s1_now;
      raw_level_next   = s1_raw;
      if (s1_raw) begin
        press_start_next = s1_now;
        long_fired_next  = 1'b0;
      end
    end

    debounced = (tdiff(s1_now, change_time_next) >= time_t'(debounce_time)) &&
                (stable_level != raw_level_next);
    if (debounced) begin
      stable_level_next = raw_level_next;
      if (!raw_level_next) begin
        if (!long_fired_next) begin
          if (tdiff(s1_now, release_time) < time_t'(double_click_window)) begin
            if (click_inc >= CLICK_DBL) begin
              dc_next            = 1'b1;
              clicks_next        = '0;
              short_pending_next = 1'b0;
            end else begin
              clicks_next         = click_inc;
              short_pending_next  = 1'b1;
              short_deadline_next = s1_now + time_t'(double_click_window);
            end
          end else begin
            clicks_next         = click_t'(1);
            short_pending_next  = 1'b1;
            short_deadline_next = s1_now + time_t'(double_click_window);
          end
          release_time_next = s1_now;
        end else begin
          // release that ends a long press counts no click
          long_fired_next = 1'b0;
          clicks_next     = '0;
        end
      end
    end

    // Long press runs off the raw level.
    if (raw_level_next && !long_fired_next &&
        (tdiff(s1_now, press_start_next) >= time_t'(long_press_time))) begin
      lp_next            = 1'b1;
      long_fired_next    = 1'b1;
      short_pending_next = 1'b0;
    end

    // Plain unsigned deadline compare; a wrapped deadline may fire early.
    if (short_pending_next && (s1_now >= short_deadline_next)) begin
      sp_next            = !raw_level_next && !long_fired_next;
      short_pending_next = 1'b0;
      clicks_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level      <= 1'b0;
      stable_level   <= 1'b0;
      change_time    <= '0;
      press_start    <= '0;
      release_time   <= '0;
      clicks         <= '0;
      short_pending  <= 1'b0;
      short_deadline <= '0;
      long_fired     <= 1'b0;
    end else if (advance && s1_valid) begin
      raw_level      <= raw_level_next;
      stable_level   <= stable_level_next;
      change_time    <= change_time_next;
      press_start    <= press_start_next;
      release_time   <= release_time_next;
      clicks         <= clicks_next;
      short_pending  <= short_pending_next;
      short_deadline <= short_deadline_next;
      long_fired     <= long_fired_next;
    end
  end

  // Stage 2: result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      feedback_bright <= stable_level_next;
      long_press      <= lp_next;
      short_press     <= sp_next;
      double_click    <= dc_next;
    end
  end

  // At most one event per result.
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({long_press, short_press, double_click}))
    else $error("more than one click event in one result");

  // A double click only comes with a debounced release.
  a_dc_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && double_click) |-> !feedback_bright)
    else $error("double click while stable level pressed");

  // An empty input register never holds off a transaction.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty input register");

  // A stalled result keeps the tracking state frozen.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(stable_level) && $stable(clicks))
    else $error("state moved while result stalled");

endmodule

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdcc_pkg::*;

  // One classifier result: the debounced level plus the three event pulses.
  typedef struct packed {
    logic bright;
    logic long_p;
    logic short_p;
    logic dbl;
  } btn_event_t;

  // Directed stimulus row. When pinned is set, ev is the hand-written expected
  // result; otherwise the row is checked against the predictor.
  typedef struct packed {
    logic       raw;
    time_t      now;
    logic       pinned;
    logic [3:0] ev;
  } dir_row_t;

  // Index past the end of the register list: the block must ignore it.
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  localparam int N_DIR   = 27;
  localparam int N_PHASE = 8;
  localparam int PHASE_ITEMS = 220;

  // Press/release script at reset timing (debounce 50, window 300, long 1000).
  // Covers: first sample after reset, a plain click, a double click, a long
  // press and its release, a bounce that never settles, a release whose
  // deadline wraps past zero (fires early), and debounce across the time wrap.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 4'b0000},  // idle after reset
    '{1'b1, 32'h0000_0064, 1'b0, 4'b0000},  // press (100)
    '{1'b1, 32'h0000_0096, 1'b1, 4'b1000},  // settles pressed (150)
    '{1'b0, 32'h0000_00C8, 1'b0, 4'b0000},  // release (200)
    '{1'b0, 32'h0000_00FA, 1'b0, 4'b0000},  // settles released, single pending
    '{1'b0, 32'h0000_0230, 1'b1, 4'b0010},  // window over: short press (560)
    '{1'b1, 32'h0000_0258, 1'b0, 4'b0000},  // first click of a double
    '{1'b1, 32'h0000_0294, 1'b0, 4'b0000},
    '{1'b0, 32'h0000_02BC, 1'b0, 4'b0000},
    '{1'b0, 32'h0000_02EE, 1'b0, 4'b0000},  // released (750)
    '{1'b1, 32'h0000_0320, 1'b0, 4'b0000},  // second click
    '{1'b1, 32'h0000_0352, 1'b0, 4'b0000},
    '{1'b0, 32'h0000_0384, 1'b0, 4'b0000},
    '{1'b0, 32'h0000_03B6, 1'b1, 4'b0001},  // released 200 ms later: double
    '{1'b1, 32'h0000_03E8, 1'b0, 4'b0000},  // long hold from 1000
    '{1'b1, 32'h0000_041A, 1'b0, 4'b0000},
    '{1'b1, 32'h0000_07D0, 1'b1, 4'b1100},  // 1000 ms held: long press
    '{1'b0, 32'h0000_0A28, 1'b0, 4'b0000},
    '{1'b0, 32'h0000_0A8C, 1'b0, 4'b0000},  // release after long: no click
    '{1'b1, 32'h0000_0A96, 1'b0, 4'b0000},  // 10 ms bounce
    '{1'b0, 32'h0000_0AA0, 1'b0, 4'b0000},
    '{1'b1, 32'hFFFF_FE00, 1'b0, 4'b0000},  // near the wrap
    '{1'b1, 32'hFFFF_FE40, 1'b0, 4'b0000},
    '{1'b0, 32'hFFFF_FE80, 1'b0, 4'b0000},
    '{1'b0, 32'hFFFF_FF00, 1'b0, 4'b0000},  // deadline wraps: fires at once
    '{1'b1, 32'hFFFF_FFFF, 1'b0, 4'b0000},  // all ones
    '{1'b1, 32'h0000_0040, 1'b0, 4'b0000}   // settles across the wrap
  };

  logic     clk;
  logic     rst;
  logic     cfg_write;
  cfg_idx_t cfg_index;
  cfg_t     cfg_data;
  logic     in_valid;
  logic     in_stall;
  logic     raw_pressed;
  logic [31:0] now_ms;
  logic     out_valid;
  logic     out_stall;
  logic     feedback_bright;
  logic     long_press;
  logic     short_press;
  logic     double_click;

  button_debounce_click_classifier dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .raw_pressed     (raw_pressed),
    .now_ms          (now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .feedback_bright (feedback_bright),
    .long_press      (long_press),
    .short_press     (short_press),
    .double_click    (double_click)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers and the tracking state.
  // --------------------------------------------------------------------------
  cfg_t   deb_ms;
  cfg_t   win_ms;
  cfg_t   hold_ms;

  logic   btn_raw;
  logic   btn_stable;
  time_t  raw_change_ms;
  time_t  press_start_ms;
  time_t  last_release_ms;
  click_t click_cnt;
  logic   single_pending;
  time_t  single_deadline;
  logic   hold_fired;

  btn_event_t predicted_events[$];

  int err_cnt;
  int items_sent;
  int n_long, n_short, n_double;
  int gap_pct;       // sender idle chance per transaction
  int stall_pct;     // receiver stall chance per cycle
  time_t clock_ms;   // running timestamp for generated samples
  logic  cur_raw;    // last raw level sent

  always #5 clk = ~clk;

  // Elapsed milliseconds, modulo 2^32.
  function automatic time_t ms_since(input time_t later, input time_t earlier);
    ms_since = later - earlier;
  endfunction

  task automatic clear_tracking();
    deb_ms          = DEBOUNCE_RST;
    win_ms          = DC_WIN_RST;
    hold_ms         = LONG_RST;
    btn_raw         = 1'b0;
    btn_stable      = 1'b0;
    raw_change_ms   = '0;
    press_start_ms  = '0;
    last_release_ms = '0;
    click_cnt       = '0;
    single_pending  = 1'b0;
    single_deadline = '0;
    hold_fired      = 1'b0;
  endtask

  // Advance the classifier by one sample and work out the result it gives.
  task automatic classify_sample(input logic raw, input time_t now, output btn_event_t ev);
    ev = '0;
    // Raw edge: restart debounce; a press also restarts long-press tracking.
    if (raw != btn_raw) begin
      raw_change_ms = now;
      btn_raw = raw;
      if (raw) begin
        press_start_ms = now;
        hold_fired = 1'b0;
      end
    end
    // Debounced edge.
    if (ms_since(now, raw_change_ms) >= time_t'(deb_ms) && btn_stable != btn_raw) begin
      btn_stable = btn_raw;
      if (!btn_stable) begin
        if (!hold_fired) begin
          if (ms_since(now, last_release_ms) < time_t'(win_ms)) begin
            if (click_cnt < CLICK_MAX) click_cnt = click_cnt + 1'b1;
            if (click_cnt >= CLICK_DBL) begin
              ev.dbl = 1'b1;
              click_cnt = '0;
              single_pending = 1'b0;
            end else begin
              single_pending = 1'b1;
              single_deadline = now + time_t'(win_ms);
            end
          end else begin
            click_cnt = click_t'(1);
            single_pending = 1'b1;
            single_deadline = now + time_t'(win_ms);
          end
          last_release_ms = now;
        end else begin
          // release after a long press counts nothing
          hold_fired = 1'b0;
          click_cnt = '0;
        end
      end
    end
    // Long press follows the raw level, not the debounced one.
    if (btn_raw && !hold_fired && ms_since(now, press_start_ms) >= time_t'(hold_ms)) begin
      ev.long_p = 1'b1;
      hold_fired = 1'b1;
      single_pending = 1'b0;
    end
    // Plain unsigned compare on purpose: a wrapped deadline fires early.
    if (single_pending && now >= single_deadline) begin
      if (!btn_raw && !hold_fired) ev.short_p = 1'b1;
      single_pending = 1'b0;
      click_cnt = '0;
    end
    ev.bright = btn_stable;
  endtask

  // --------------------------------------------------------------------------
  // Driver side
  // --------------------------------------------------------------------------

  // Offer one sample and hold it until the block takes it. Valid stays high
  // afterwards so back-to-back transactions need no extra edge.
  task automatic send_sample(input logic raw, input time_t now,
                             input logic pinned, input btn_event_t pinned_ev);
    btn_event_t ev;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    raw_pressed <= raw;
    now_ms      <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    classify_sample(raw, now, ev);
    predicted_events.push_back(pinned ? pinned_ev : ev);
    cur_raw = raw;
    items_sent++;
  endtask

  task automatic send_random(input logic raw, input time_t now);
    send_sample(raw, now, 1'b0, '0);
  endtask

  // Register writes happen only while the block is drained. cfg_write is left
  // high between back-to-back writes and lowered once at the end.
  task automatic write_reg(input cfg_idx_t idx, input cfg_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_DEBOUNCE: deb_ms  = val;
      REG_DC_WIN:   win_ms  = val;
      REG_LONG:     hold_ms = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_t deb, input cfg_t win, input cfg_t hold);
    write_reg(REG_UNUSED, cfg_t'($urandom));
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_DC_WIN, win);
    write_reg(REG_LONG, hold);
    cfg_write <= 1'b0;
  endtask

  // Let every outstanding result come back and the input and result registers
  // empty before anything else touches the block.
  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One stretch of button activity: mostly a held level of a length chosen
  // around the current timings (too short, click-length, past the window,
  // past the long-press time), sometimes led by contact bounce. A small share
  // is pure noise with arbitrary timestamps.
  task automatic play_gesture();
    logic        lvl;
    int unsigned dur;
    int unsigned n;
    int unsigned step;
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        clock_ms = time_t'($urandom);
        send_random(1'($urandom), clock_ms);
      end
    end else begin
      lvl = ($urandom_range(0, 9) == 0) ? cur_raw : !cur_raw;
      case ($urandom_range(0, 7))
        0:       dur = $urandom_range(0, deb_ms);
        1, 2, 3: dur = deb_ms + $urandom_range(0, win_ms / 2 + 1);
        4:       dur = deb_ms + $urandom_range(0, win_ms + 10);
        5:       dur = hold_ms + $urandom_range(0, 20);
        6:       dur = $urandom_range(0, hold_ms + deb_ms + 10);
        default: dur = $urandom_range(0, 3);
      endcase
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          clock_ms = clock_ms + $urandom_range(0, deb_ms / 4 + 1);
          send_random(!cur_raw, clock_ms);
        end
      end
      n = $urandom_range(1, 4);
      repeat (n) begin
        step = dur / n;
        step = step + $urandom_range(0, step / 4 + 1);
        clock_ms = clock_ms + step;
        send_random(lvl, clock_ms);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  task automatic check_field(input string what, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %b, actual %b", $time, what, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    btn_event_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %b%b%b%b", $time,
                 feedback_bright, long_press, short_press, double_click);
        err_cnt++;
      end else begin
        want = predicted_events.pop_front();
        check_field("feedback_bright", want.bright,  feedback_bright);
        check_field("long_press",      want.long_p,  long_press);
        check_field("short_press",     want.short_p, short_press);
        check_field("double_click",    want.dbl,     double_click);
        n_long   += want.long_p;
        n_short  += want.short_p;
        n_double += want.dbl;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed script, then random phases that cycle through
  // register settings (both extremes, reset values, random) and idle modes.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    err_cnt = 0;
    items_sent = 0;
    n_long = 0;
    n_short = 0;
    n_double = 0;
    gap_pct = 0;
    stall_pct = 0;
    cur_raw = 1'b0;
    clock_ms = '0;
    clear_tracking();
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_DEBOUNCE;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    raw_pressed <= 1'b0;
    now_ms      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part runs on the reset register values, no idling
    for (int i = 0; i < N_DIR; i++)
      send_sample(DIR_ROWS[i].raw, DIR_ROWS[i].now, DIR_ROWS[i].pinned,
                  btn_event_t'(DIR_ROWS[i].ev));

    for (int p = 0; p < N_PHASE; p++) begin
      int phase_start;
      drain();
      case (p)
        0:       set_config('0, '0, '0);
        1:       set_config('1, '1, '1);
        2:       set_config(DEBOUNCE_RST, DC_WIN_RST, LONG_RST);
        7:       set_config(cfg_t'($urandom), cfg_t'($urandom), cfg_t'($urandom));
        default: set_config(cfg_t'($urandom_range(0, 60)), cfg_t'($urandom_range(0, 500)),
                            cfg_t'($urandom_range(0, 1500)));
      endcase
      // idle mode rotates: none, sender, receiver, both
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 63; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 63; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      // one phase starts just short of the time wrap
      clock_ms = (p == 4) ? time_t'(32'hFFFF_FFFF - $urandom_range(0, 20000))
                          : time_t'($urandom);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) play_gesture();
    end

    drain();
    gap_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("Ran %0d samples over %0d register settings and four idle modes,",
             items_sent, N_PHASE + 1);
    $display("seeing %0d long presses, %0d short presses, %0d double clicks.",
             n_long, n_short, n_double);
    if (err_cnt == 0 && predicted_events.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
